### rtl/core/bounded_byte_stream_fifo_macros.svh
// assertion helpers shared by the fifo core
`ifndef BOUNDED_BYTE_STREAM_FIFO_MACROS_SVH
`define BOUNDED_BYTE_STREAM_FIFO_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define BBF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define BBF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bbf_pkg.sv
package bbf_pkg;

    // storage geometry
    localparam int BUF_DEPTH = 1024;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);

    // field widths
    localparam int LVL_W     = 11;
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int TOT_W     = 32;
    localparam int OP_W      = 3;

    // longest peek or read burst
    localparam int MAX_BURST = 64;

    // capacity after reset
    localparam logic [LVL_W-1:0] CAP_RESET = LVL_W'(1024);

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 3'd0,
        OP_PEEK   = 3'd1,
        OP_POP    = 3'd2,
        OP_READ   = 3'd3,
        OP_END    = 3'd4,
        OP_STATUS = 3'd5
    } op_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t              op;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  burst;
    } cmd_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
    } q_status_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_BURST_RD,
        B_BURST_OUT
    } back_state_t;

endpackage

### rtl/core/bbf_front.sv
module bbf_front (
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bbf_pkg::OP_W-1:0]     s_op,
    input  logic [bbf_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic [bbf_pkg::LEN_W-1:0]    s_length,
    input  bbf_pkg::q_status_t           q_status,
    output logic                         q_push,
    output bbf_pkg::cmd_t                q_cmd
);

    // take an item whenever the queue has a free slot
    assign s_ready = !q_status.full;
    assign q_push  = s_valid && !q_status.full;

    // classify the op; unused codes behave as status
    always_comb begin
        q_cmd.data = s_data_byte;
        q_cmd.len  = s_length;
        unique case (s_op)
            bbf_pkg::OP_WRITE:  q_cmd.op = bbf_pkg::OP_WRITE;
            bbf_pkg::OP_PEEK:   q_cmd.op = bbf_pkg::OP_PEEK;
            bbf_pkg::OP_POP:    q_cmd.op = bbf_pkg::OP_POP;
            bbf_pkg::OP_READ:   q_cmd.op = bbf_pkg::OP_READ;
            bbf_pkg::OP_END:    q_cmd.op = bbf_pkg::OP_END;
            default:            q_cmd.op = bbf_pkg::OP_STATUS;
        endcase
    end

    // burst length saturated for peek and read
    always_comb begin
        if (s_length > bbf_pkg::LEN_W'(bbf_pkg::MAX_BURST)) begin
            q_cmd.burst = bbf_pkg::LEN_W'(bbf_pkg::MAX_BURST);
        end else begin
            q_cmd.burst = s_length;
        end
    end

endmodule

### rtl/core/bbf_queue.sv
module bbf_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bbf_pkg::cmd_t       push_cmd,
    output bbf_pkg::q_status_t  status,
    input  logic                pop,
    output logic                pop_valid,
    output bbf_pkg::cmd_t       pop_cmd
);

    bbf_pkg::cmd_t                    entry_reg [bbf_pkg::Q_DEPTH];
    logic [bbf_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [bbf_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [bbf_pkg::Q_LVL_W-1:0]      lvl_reg, lvl_next;
    logic                             do_push, do_pop;

    assign status.full = (lvl_reg == bbf_pkg::Q_LVL_W'(bbf_pkg::Q_DEPTH));
    assign pop_valid   = (lvl_reg != '0);
    assign pop_cmd     = entry_reg[rd_ptr_reg];
    assign do_push     = push && !status.full;
    assign do_pop      = pop && pop_valid;

    // pointer and level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        lvl_next    = lvl_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == bbf_pkg::Q_PTR_W'(bbf_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + bbf_pkg::Q_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == bbf_pkg::Q_PTR_W'(bbf_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + bbf_pkg::Q_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            lvl_next = lvl_reg + bbf_pkg::Q_LVL_W'(1);
        end else if (do_pop && !do_push) begin
            lvl_next = lvl_reg - bbf_pkg::Q_LVL_W'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            lvl_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            lvl_reg    <= lvl_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/bbf_back.sv
`include "bounded_byte_stream_fifo_macros.svh"

module bbf_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bbf_pkg::LVL_W-1:0]    cfg_wr_data,
    input  logic                         q_valid,
    input  bbf_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bbf_pkg::BYTE_W-1:0]   m_data_out,
    output logic                         m_data_valid,
    output logic                         m_last,
    output logic                         m_accepted,
    output logic                         m_error_flag,
    output logic [bbf_pkg::LVL_W-1:0]    m_fill_level,
    output logic [bbf_pkg::LVL_W-1:0]    m_room_left,
    output logic                         m_stream_ended,
    output logic                         m_end_of_file,
    output logic [bbf_pkg::TOT_W-1:0]    m_total_written,
    output logic [bbf_pkg::TOT_W-1:0]    m_total_read
);

    // byte memory and its registered read port
    logic [bbf_pkg::BYTE_W-1:0] mem [bbf_pkg::BUF_DEPTH];
    logic [bbf_pkg::BYTE_W-1:0] rdata_reg;

    // fifo state
    bbf_pkg::back_state_t          state_reg, state_next;
    logic [bbf_pkg::LVL_W-1:0]     cap_reg;
    logic [bbf_pkg::ADDR_W-1:0]    head_reg, head_next;
    logic [bbf_pkg::LVL_W-1:0]     count_reg, count_next;
    logic [bbf_pkg::TOT_W-1:0]     wr_cnt_reg, wr_cnt_next;
    logic [bbf_pkg::TOT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                          ended_reg, ended_next;
    logic                          err_reg, err_next;

    // burst sequencing
    logic [bbf_pkg::LEN_W-1:0]     idx_reg, idx_next;
    logic [bbf_pkg::LEN_W-1:0]     n_reg, n_next;
    logic                          remove_reg, remove_next;

    // output register
    logic                          m_valid_reg;
    logic [bbf_pkg::BYTE_W-1:0]    m_data_out_reg;
    logic                          m_data_valid_reg;
    logic                          m_last_reg;
    logic                          m_accepted_reg;
    logic                          m_error_flag_reg;
    logic [bbf_pkg::LVL_W-1:0]     m_fill_level_reg;
    logic [bbf_pkg::LVL_W-1:0]     m_room_left_reg;
    logic                          m_stream_ended_reg;
    logic                          m_end_of_file_reg;
    logic [bbf_pkg::TOT_W-1:0]     m_total_written_reg;
    logic [bbf_pkg::TOT_W-1:0]     m_total_read_reg;

    // per-cycle decisions
    logic                          out_free;
    logic                          out_load;
    logic                          start_burst;
    logic                          last_beat;
    logic                          mem_we;
    logic [bbf_pkg::ADDR_W-1:0]    wr_addr;
    logic [bbf_pkg::ADDR_W-1:0]    rd_addr;
    logic [bbf_pkg::BYTE_W-1:0]    o_data;
    logic                          o_dvalid;
    logic                          o_last;
    logic                          o_acc;
    logic [bbf_pkg::LVL_W-1:0]     cap_eff;
    logic [bbf_pkg::LVL_W-1:0]     room_next;
    logic [bbf_pkg::LEN_W-1:0]     peek_n;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_beat = (idx_reg + bbf_pkg::LEN_W'(1)) == n_reg;
    assign wr_addr   = head_reg + count_reg[bbf_pkg::ADDR_W-1:0];
    assign rd_addr   = head_reg + (remove_reg ? '0 : bbf_pkg::ADDR_W'(idx_reg));

    // capacity saturated to the buffer size
    assign cap_eff = (cap_reg > bbf_pkg::LVL_W'(bbf_pkg::BUF_DEPTH)) ?
                     bbf_pkg::LVL_W'(bbf_pkg::BUF_DEPTH) : cap_reg;
    assign room_next = (cap_eff > count_next) ? (cap_eff - count_next) : '0;

    // peek emits no more than what is buffered
    assign peek_n = (bbf_pkg::LVL_W'(q_cmd.burst) < count_reg) ?
                    q_cmd.burst : count_reg[bbf_pkg::LEN_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bbf_pkg::B_IDLE: begin
                if (start_burst) begin
                    state_next = bbf_pkg::B_BURST_RD;
                end
            end
            bbf_pkg::B_BURST_RD: begin
                state_next = bbf_pkg::B_BURST_OUT;
            end
            bbf_pkg::B_BURST_OUT: begin
                if (out_free) begin
                    state_next = last_beat ? bbf_pkg::B_IDLE : bbf_pkg::B_BURST_RD;
                end
            end
            default: state_next = bbf_pkg::B_IDLE;
        endcase
    end

    // command execution and result forming
    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        wr_cnt_next = wr_cnt_reg;
        rd_cnt_next = rd_cnt_reg;
        ended_next  = ended_reg;
        err_next    = err_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        remove_next = remove_reg;
        q_pop       = 1'b0;
        out_load    = 1'b0;
        start_burst = 1'b0;
        mem_we      = 1'b0;
        o_data      = '0;
        o_dvalid    = 1'b0;
        o_last      = 1'b1;
        o_acc       = 1'b0;
        unique case (state_reg)
            bbf_pkg::B_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        bbf_pkg::OP_WRITE: begin
                            out_load = 1'b1;
                            if (count_reg < cap_eff) begin
                                mem_we      = 1'b1;
                                count_next  = count_reg + bbf_pkg::LVL_W'(1);
                                wr_cnt_next = wr_cnt_reg + bbf_pkg::TOT_W'(1);
                                o_acc       = 1'b1;
                            end
                        end
                        bbf_pkg::OP_PEEK: begin
                            if (peek_n == '0) begin
                                out_load = 1'b1;
                            end else begin
                                start_burst = 1'b1;
                                n_next      = peek_n;
                                idx_next    = '0;
                                remove_next = 1'b0;
                            end
                        end
                        bbf_pkg::OP_POP: begin
                            out_load = 1'b1;
                            if (bbf_pkg::LVL_W'(q_cmd.len) > count_reg) begin
                                err_next = 1'b1;
                            end else begin
                                head_next   = head_reg + bbf_pkg::ADDR_W'(q_cmd.len);
                                count_next  = count_reg - bbf_pkg::LVL_W'(q_cmd.len);
                                rd_cnt_next = rd_cnt_reg + bbf_pkg::TOT_W'(q_cmd.len);
                                o_acc       = 1'b1;
                            end
                        end
                        bbf_pkg::OP_READ: begin
                            if (bbf_pkg::LVL_W'(q_cmd.burst) > count_reg) begin
                                out_load = 1'b1;
                                err_next = 1'b1;
                            end else if (q_cmd.burst == '0) begin
                                out_load = 1'b1;
                                o_acc    = 1'b1;
                            end else begin
                                start_burst = 1'b1;
                                n_next      = q_cmd.burst;
                                idx_next    = '0;
                                remove_next = 1'b1;
                            end
                        end
                        bbf_pkg::OP_END: begin
                            out_load   = 1'b1;
                            ended_next = 1'b1;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            bbf_pkg::B_BURST_RD: begin
                // memory read in flight
            end
            bbf_pkg::B_BURST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    o_data   = rdata_reg;
                    o_dvalid = 1'b1;
                    o_last   = last_beat;
                    o_acc    = remove_reg;
                    idx_next = idx_reg + bbf_pkg::LEN_W'(1);
                    if (remove_reg) begin
                        head_next   = head_reg + bbf_pkg::ADDR_W'(1);
                        count_next  = count_reg - bbf_pkg::LVL_W'(1);
                        rd_cnt_next = rd_cnt_reg + bbf_pkg::TOT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bbf_pkg::B_IDLE;
            cap_reg     <= bbf_pkg::CAP_RESET;
            head_reg    <= '0;
            count_reg   <= '0;
            wr_cnt_reg  <= '0;
            rd_cnt_reg  <= '0;
            ended_reg   <= 1'b0;
            err_reg     <= 1'b0;
            idx_reg     <= '0;
            n_reg       <= '0;
            remove_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            head_reg    <= head_next;
            count_reg   <= count_next;
            wr_cnt_reg  <= wr_cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
            ended_reg   <= ended_next;
            err_reg     <= err_next;
            idx_reg     <= idx_next;
            n_reg       <= n_next;
            remove_reg  <= remove_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, reported after this item's update
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_out_reg      <= o_data;
            m_data_valid_reg    <= o_dvalid;
            m_last_reg          <= o_last;
            m_accepted_reg      <= o_acc;
            m_error_flag_reg    <= err_next;
            m_fill_level_reg    <= count_next;
            m_room_left_reg     <= room_next;
            m_stream_ended_reg  <= ended_next;
            m_end_of_file_reg   <= ended_next && (count_next == '0);
            m_total_written_reg <= wr_cnt_next;
            m_total_read_reg    <= rd_cnt_next;
        end
    end

    // byte memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= q_cmd.data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign m_valid         = m_valid_reg;
    assign m_data_out      = m_data_out_reg;
    assign m_data_valid    = m_data_valid_reg;
    assign m_last          = m_last_reg;
    assign m_accepted      = m_accepted_reg;
    assign m_error_flag    = m_error_flag_reg;
    assign m_fill_level    = m_fill_level_reg;
    assign m_room_left     = m_room_left_reg;
    assign m_stream_ended  = m_stream_ended_reg;
    assign m_end_of_file   = m_end_of_file_reg;
    assign m_total_written = m_total_written_reg;
    assign m_total_read    = m_total_read_reg;

    // checks on the fifo bookkeeping
    `BBF_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= bbf_pkg::LVL_W'(bbf_pkg::BUF_DEPTH), "fill level beyond buffer depth")
    `BBF_ASSERT_NXT(a_write_reported, mem_we, m_valid_reg && m_accepted_reg && !m_data_valid_reg, "stored byte not reported as taken")
    `BBF_ASSERT_IMP(a_burst_index, state_reg != bbf_pkg::B_IDLE, idx_reg < n_reg, "burst index past burst length")
    `BBF_ASSERT_IMP(a_read_not_empty, (state_reg != bbf_pkg::B_IDLE) && remove_reg, count_reg != '0, "read burst on empty buffer")

endmodule

### rtl/core/bounded_byte_stream_fifo.sv
// Byte FIFO of up to 1024 entries with a programmable capacity (cfg_wr_en /
// cfg_wr_data, reset value 1024, values above 1024 act as 1024; write it only
// while the block is idle). Every item gives one result, except a peek or read
// that moves bytes, which gives one result per byte with last on the final one.
// Items enter a two-deep command queue, so s_ready stays high while the back end
// works unless the queue is full. A write, pop, end or status item is taken from
// the queue once the back end is idle and the output register is free; its result
// is loaded into the output register at that same edge. Each burst byte is read
// through the registered memory port, then loaded into the output register once
// that is free; the next byte is read only after that load. The memory needs no
// clearing after reset: only bytes below the fill level are ever read.
module bounded_byte_stream_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bbf_pkg::LVL_W-1:0]    cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bbf_pkg::OP_W-1:0]     s_op,
    input  logic [bbf_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic [bbf_pkg::LEN_W-1:0]    s_length,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bbf_pkg::BYTE_W-1:0]   m_data_out,
    output logic                         m_data_valid,
    output logic                         m_last,
    output logic                         m_accepted,
    output logic                         m_error_flag,
    output logic [bbf_pkg::LVL_W-1:0]    m_fill_level,
    output logic [bbf_pkg::LVL_W-1:0]    m_room_left,
    output logic                         m_stream_ended,
    output logic                         m_end_of_file,
    output logic [bbf_pkg::TOT_W-1:0]    m_total_written,
    output logic [bbf_pkg::TOT_W-1:0]    m_total_read
);

    bbf_pkg::q_status_t q_status;
    bbf_pkg::cmd_t      push_cmd;
    bbf_pkg::cmd_t      pop_cmd;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;

    // item decode
    bbf_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_byte (s_data_byte),
        .s_length    (s_length),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    // command queue
    bbf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .status    (q_status),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    // execution and result output
    bbf_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .q_valid         (q_valid),
        .q_cmd           (pop_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_out      (m_data_out),
        .m_data_valid    (m_data_valid),
        .m_last          (m_last),
        .m_accepted      (m_accepted),
        .m_error_flag    (m_error_flag),
        .m_fill_level    (m_fill_level),
        .m_room_left     (m_room_left),
        .m_stream_ended  (m_stream_ended),
        .m_end_of_file   (m_end_of_file),
        .m_total_written (m_total_written),
        .m_total_read    (m_total_read)
    );

endmodule
